>>> src/cpt_pkg.sv
// Shared types, constants and the sine table for the Clarke/Park transform unit.
`default_nettype none

package cpt_pkg;

	localparam int FRACTION_BITS = 12;
	localparam int SINE_ENTRIES  = 256;
	localparam int IDX_W         = $clog2(SINE_ENTRIES);
	localparam int ONE           = 1 << FRACTION_BITS;

	localparam logic [63:0] HALFPI_Q62 = 64'h6487ED5110B4611A;

	typedef enum logic [1:0] {
		OP_CLARKE     = 2'd0,
		OP_INV_CLARKE = 2'd1,
		OP_PARK       = 2'd2,
		OP_INV_PARK   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] in_x;
		logic signed [15:0] in_y;
		logic        [15:0] rotor_angle;
	} cpt_cmd_t;

	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
	} cpt_res_t;

	// table address plus sign for one sine or cosine lookup
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             neg;
	} lookup_t;

	typedef logic [SINE_ENTRIES-1:0][15:0] sine_rom_t;

	// (a*b) >> 62, elaboration only
	function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
		logic [127:0] pr;
		pr = {64'd0, a} * {64'd0, b};
		return pr[125:62];
	endfunction

	// floor(n / d) by long division, elaboration only
	function automatic logic [63:0] div_u64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// quarter-wave table, round(ONE*sin(i*pi/(2*N))) by series in Q62
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] dv;
		r = '0;
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			x = (HALFPI_Q62 / SINE_ENTRIES) * 64'(i)
				+ ((HALFPI_Q62 % SINE_ENTRIES) * 64'(i)) / SINE_ENTRIES;
			x2   = mul_q62(x, x);
			term = x;
			sum  = x;
			for (int k = 1; k < 40; k++) begin
				if (term != 64'd0) begin
					dv   = 64'((2 * k) * (2 * k + 1));
					term = div_u64(mul_q62(term, x2), dv);
					if (k % 2 == 1)
						sum = sum - term;
					else
						sum = sum + term;
				end
			end
			r[i] = 16'((sum + (64'd1 << (61 - FRACTION_BITS))) >> (62 - FRACTION_BITS));
		end
		return r;
	endfunction

	// largest n with (n - 1/2)^2 <= num4 / (4*den)
	function automatic int round_sqrt(logic [63:0] num4, logic [63:0] den);
		logic [63:0] n;
		logic [63:0] t;
		n = 64'd0;
		for (int b = 16; b >= 0; b--) begin
			t = n | (64'd1 << b);
			if (t <= 64'd65536 && den * ((2 * t - 1) * (2 * t - 1)) <= num4)
				n = t;
		end
		return int'(n);
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	localparam logic signed [15:0] K13_COEF =
		16'(round_sqrt(64'(4) * 64'(ONE) * 64'(ONE), 64'd3));
	localparam logic signed [15:0] K32_COEF =
		16'(round_sqrt(64'(3) * 64'(ONE) * 64'(ONE), 64'd1));

endpackage

`default_nettype wire

>>> src/cpt_sine_lookup.sv
// Signed sine/cosine value from the quarter-wave table.
`default_nettype none

module cpt_sine_lookup (
	input  cpt_pkg::lookup_t   lk,
	output logic signed [15:0] value
);
	import cpt_pkg::*;

	logic signed [15:0] mag;

	always_comb begin
		mag   = $signed(SINE_ROM[lk.idx]);
		value = lk.neg ? -mag : mag;
	end

endmodule

`default_nettype wire

>>> src/clarke_park_transform_unit.sv
// Top level: four-stage Clarke / inverse Clarke / Park / inverse Park pipeline.
// Throughput: one item per cycle while the result side does not stall; the stage register chain
// with per-stage valid bits and a per-stage enable sets this, and empty stages close up behind a stalled result.
// Stages: angle fold, table lookup and operand select, four 16x16 products, scale and sum.
// Reset clears the stage valid bits only; the sine table is constant logic.
`default_nettype none

module clarke_park_transform_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cpt_pkg::cpt_cmd_t cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output cpt_pkg::cpt_res_t res
);
	import cpt_pkg::*;

	localparam int PROD_W = 14 + IDX_W + 1;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// stage 1
	op_t                op_s1;
	logic signed [15:0] x_s1, y_s1, sum_s1, half_s1;
	lookup_t            sin_lk_s1, cos_lk_s1;

	logic [PROD_W-1:0]  idx_prod;
	logic [IDX_W-1:0]   idx_fwd, idx_rev;
	logic [1:0]         quad, cos_quad;
	logic signed [16:0] neg_x, half_tmp;
	lookup_t            sin_lk, cos_lk;

	// stage 2
	op_t                op_s2;
	logic signed [15:0] x_s2, half_s2;
	logic signed [15:0] opa_s2 [4];
	logic signed [15:0] opb_s2 [4];
	logic signed [15:0] sin_v, cos_v;
	logic signed [15:0] opa [4];
	logic signed [15:0] opb [4];

	// stage 3
	op_t                op_s3;
	logic signed [15:0] x_s3, half_s3;
	logic signed [31:0] prod_s3 [4];

	// stage 4
	cpt_res_t           res_s4;
	logic signed [15:0] m [4];
	cpt_res_t           res_d;

	assign en_s4     = !vld_s4 || !res_stall;
	assign en_s3     = !vld_s3 || en_s4;
	assign en_s2     = !vld_s2 || en_s3;
	assign en_s1     = !vld_s1 || en_s2;
	assign cmd_stall = !en_s1;
	assign res_valid = vld_s4;
	assign res       = res_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= cmd_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	// stage 1: fold the angle into table address and sign; cosine is one quadrant on
	always_comb begin
		idx_prod = PROD_W'(cmd.rotor_angle[13:0]) * PROD_W'(SINE_ENTRIES);
		idx_fwd  = idx_prod[14 +: IDX_W];
		idx_rev  = IDX_W'(SINE_ENTRIES - 1) - idx_fwd;
		quad     = cmd.rotor_angle[15:14];
		cos_quad = quad + 2'd1;
		sin_lk.idx = quad[0] ? idx_rev : idx_fwd;
		sin_lk.neg = quad[1];
		cos_lk.idx = cos_quad[0] ? idx_rev : idx_fwd;
		cos_lk.neg = cos_quad[1];
		// -x/2 truncated toward zero, on 17 bits so that -(-32768) survives
		neg_x    = -$signed({cmd.in_x[15], cmd.in_x});
		half_tmp = neg_x + $signed({16'd0, neg_x[16]});
	end

	always_ff @(posedge clk) begin
		if (en_s1 && cmd_valid) begin
			op_s1     <= cmd.op;
			x_s1      <= cmd.in_x;
			y_s1      <= cmd.in_y;
			sum_s1    <= cmd.in_x + {cmd.in_y[14:0], 1'b0};
			half_s1   <= half_tmp[16:1];
			sin_lk_s1 <= sin_lk;
			cos_lk_s1 <= cos_lk;
		end
	end

	// stage 2: table lookup and multiplier operand select
	cpt_sine_lookup u_sin (
		.lk    (sin_lk_s1),
		.value (sin_v)
	);

	cpt_sine_lookup u_cos (
		.lk    (cos_lk_s1),
		.value (cos_v)
	);

	always_comb begin
		opa[0] = x_s1;
		opb[0] = cos_v;
		opa[1] = y_s1;
		opb[1] = sin_v;
		opa[2] = x_s1;
		opb[2] = sin_v;
		opa[3] = y_s1;
		opb[3] = cos_v;
		unique case (op_s1)
			OP_CLARKE: begin
				opa[3] = K13_COEF;
				opb[3] = sum_s1;
			end
			OP_INV_CLARKE: begin
				opa[3] = K32_COEF;
				opb[3] = y_s1;
			end
			OP_PARK: begin
				opa[2] = -x_s1;
			end
			OP_INV_PARK: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			op_s2   <= op_s1;
			x_s2    <= x_s1;
			half_s2 <= half_s1;
			for (int k = 0; k < 4; k++) begin
				opa_s2[k] <= opa[k];
				opb_s2[k] <= opb[k];
			end
		end
	end

	// stage 3: products
	always_ff @(posedge clk) begin
		if (en_s3 && vld_s2) begin
			op_s3   <= op_s2;
			x_s3    <= x_s2;
			half_s3 <= half_s2;
			for (int k = 0; k < 4; k++)
				prod_s3[k] <= opa_s2[k] * opb_s2[k];
		end
	end

	// stage 4: divide by ONE toward zero, wrap, combine
	function automatic logic signed [15:0] scale(logic signed [31:0] p);
		logic [31:0] t;
		t = p + (p[31] ? 32'(ONE - 1) : 32'd0);
		return t[FRACTION_BITS +: 16];
	endfunction

	always_comb begin
		for (int k = 0; k < 4; k++)
			m[k] = scale(prod_s3[k]);
		res_d.out_x = m[0] + m[1];
		res_d.out_y = m[2] + m[3];
		unique case (op_s3)
			OP_CLARKE: begin
				res_d.out_x = x_s3;
				res_d.out_y = m[3];
			end
			OP_INV_CLARKE: begin
				res_d.out_x = x_s3;
				res_d.out_y = half_s3 + m[3];
			end
			OP_PARK: begin
			end
			OP_INV_PARK: begin
				res_d.out_x = m[0] - m[1];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3)
			res_s4 <= res_d;
	end

endmodule

`default_nettype wire

>>> src/cpt_checker.sv
// Port-level assertions for the transform unit, bound to the top level.
`default_nettype none

module cpt_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_stall,
	input wire cpt_pkg::cpt_cmd_t cmd,
	input wire logic              res_valid,
	input wire logic              res_stall,
	input wire cpt_pkg::cpt_res_t res
);
	import cpt_pkg::*;

	logic cmd_acc;
	assign cmd_acc = cmd_valid && !cmd_stall;

	res_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result withdrawn while stalled");

	res_item_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("stalled result changed");

	// with no stall on the result side an accepted item reaches res_valid
	latency_four: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc ##1 !res_stall ##1 !res_stall ##1 !res_stall |=> res_valid)
		else $error("item not delivered after four free cycles");

	clarke_x_passes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd.op == OP_CLARKE ##1 !res_stall ##1 !res_stall ##1 !res_stall
		|=> res.out_x == $past(cmd.in_x, 4))
		else $error("Clarke out_x differs from phase a");

endmodule

bind clarke_park_transform_unit cpt_checker u_cpt_checker (.*);

`default_nettype wire

>>> tb/clarke_park_result_check.sv
// Result checker for the Clarke/Park transform unit: predicts each pair and compares it.
module clarke_park_result_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_stall,
	input  cpt_pkg::cpt_cmd_t cmd,
	input  logic              res_valid,
	input  logic              res_stall,
	input  cpt_pkg::cpt_res_t res,
	output int                errors,
	output int                pending
);
	import cpt_pkg::*;

	localparam int  QUARTER_TURN = 16384;
	localparam real PI_VAL       = 3.14159265358979323846;

	int       quarter_sine [SINE_ENTRIES];
	int       k_inv_sqrt3;
	int       k_half_sqrt3;
	cpt_res_t expected_pairs [$];

	initial begin
		for (int i = 0; i < SINE_ENTRIES; i++) begin
			quarter_sine[i] = int'($floor(real'(ONE) *
				$sin(PI_VAL * i / (2.0 * SINE_ENTRIES)) + 0.5));
		end
		k_inv_sqrt3  = int'($floor(real'(ONE) / $sqrt(3.0) + 0.5));
		k_half_sqrt3 = int'($floor(real'(ONE) * $sqrt(3.0) / 2.0 + 0.5));
	end

	function automatic int wrap16(int v);
		logic signed [15:0] t;
		t = v[15:0];
		return int'(t);
	endfunction

	// fixed-point product, truncated toward zero
	function automatic int scaled_product(int p, int r);
		return wrap16((p * r) / ONE);
	endfunction

	function automatic int sine_at(logic [15:0] ang);
		int idx;
		int mirrored;
		idx      = ((int'(ang) & (QUARTER_TURN - 1)) * SINE_ENTRIES) >> 14;
		mirrored = SINE_ENTRIES - 1 - idx;
		if (int'(ang) < QUARTER_TURN)
			return quarter_sine[idx];
		else if (int'(ang) < 2 * QUARTER_TURN)
			return quarter_sine[mirrored];
		else if (int'(ang) < 3 * QUARTER_TURN)
			return -quarter_sine[idx];
		else
			return -quarter_sine[mirrored];
	endfunction

	function automatic cpt_res_t transform_pair(cpt_cmd_t c);
		int       x;
		int       y;
		int       rx;
		int       ry;
		int       s;
		int       co;
		cpt_res_t r;
		x  = int'(c.in_x);
		y  = int'(c.in_y);
		s  = sine_at(c.rotor_angle);
		co = sine_at(16'(c.rotor_angle + 16'h4000));
		case (c.op)
			OP_CLARKE: begin
				rx = x;
				ry = scaled_product(k_inv_sqrt3, wrap16(x + 2 * y));
			end
			OP_INV_CLARKE: begin
				rx = x;
				ry = wrap16((-x) / 2 + scaled_product(k_half_sqrt3, y));
			end
			OP_PARK: begin
				rx = wrap16(scaled_product(x, co) + scaled_product(y, s));
				ry = wrap16(scaled_product(wrap16(-x), s) + scaled_product(y, co));
			end
			default: begin
				rx = wrap16(scaled_product(x, co) - scaled_product(y, s));
				ry = wrap16(scaled_product(x, s) + scaled_product(y, co));
			end
		endcase
		r.out_x = rx[15:0];
		r.out_y = ry[15:0];
		return r;
	endfunction

	always @(posedge clk) begin
		cpt_res_t want;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_pairs.size() == 0) begin
					errors++;
					$display("%0t: unexpected result x=%0d y=%0d", $time, res.out_x, res.out_y);
				end else begin
					want = expected_pairs.pop_front();
					if (res.out_x !== want.out_x) begin
						errors++;
						$display("%0t: out_x expected %0d got %0d",
							$time, want.out_x, res.out_x);
					end
					if (res.out_y !== want.out_y) begin
						errors++;
						$display("%0t: out_y expected %0d got %0d",
							$time, want.out_y, res.out_y);
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				expected_pairs.push_back(transform_pair(cmd));
			pending <= expected_pairs.size();
		end
	end

endmodule

>>> tb/clarke_park_transform_unit_tb.sv
// Testbench top for the Clarke/Park transform unit: stimulus, receiver stalls and verdict.
module clarke_park_transform_unit_tb;
	import cpt_pkg::*;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	cpt_cmd_t    cmd       = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	cpt_res_t    res;
	int          errors;
	int          pending;
	int          burst_left = 0;
	int          stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	clarke_park_transform_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	clarke_park_result_check result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.errors    (errors),
		.pending   (pending)
	);

	// receiver back-pressure: switches to a randomly chosen pattern when its countdown runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(16, 80);
		end else
			stall_left <= stall_left - 1;
		case (stall_mode)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 7);
			default:     res_stall <= stall_left[2];
		endcase
	end

	function automatic cpt_cmd_t make_item(op_t op, int x, int y, int ang);
		cpt_cmd_t c;
		c.op          = op;
		c.in_x        = 16'(x);
		c.in_y        = 16'(y);
		c.rotor_angle = 16'(ang);
		return c;
	endfunction

	function automatic int pick_value();
		case ($urandom_range(0, 9))
			0:       return -32768;
			1:       return 32767;
			2:       return int'($urandom_range(0, 64)) - 32;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// quadrant boundaries get extra weight
	function automatic int pick_angle();
		if ($urandom_range(0, 4) == 0)
			return 16384 * int'($urandom_range(0, 3)) + int'($urandom_range(0, 2)) - 1;
		return int'($urandom_range(0, 65535));
	endfunction

	task automatic issue(cpt_cmd_t c);
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
	endtask

	// called once after every accepted item; drain waits for all results
	task automatic pace(bit drain);
		int gap;
		if (drain) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while (pending != 0);
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 8);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		cpt_cmd_t directed_items [$];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, wrap of a+2b, halving of the most negative alpha, quadrant edges
		directed_items.push_back(make_item(OP_CLARKE, 0, 0, 0));
		directed_items.push_back(make_item(OP_CLARKE, 32767, 32767, 0));
		directed_items.push_back(make_item(OP_CLARKE, -32768, -32768, 0));
		directed_items.push_back(make_item(OP_CLARKE, 16384, -8192, 65535));
		directed_items.push_back(make_item(OP_CLARKE, -1, 16383, 4660));
		directed_items.push_back(make_item(OP_INV_CLARKE, -32768, 32767, 0));
		directed_items.push_back(make_item(OP_INV_CLARKE, -1, -32768, 0));
		directed_items.push_back(make_item(OP_INV_CLARKE, 1, 1, 65535));
		directed_items.push_back(make_item(OP_INV_CLARKE, 32767, -1, 0));
		directed_items.push_back(make_item(OP_INV_CLARKE, -3, 0, 30000));
		directed_items.push_back(make_item(OP_PARK, 32767, 0, 0));
		directed_items.push_back(make_item(OP_PARK, -32768, 32767, 16383));
		directed_items.push_back(make_item(OP_PARK, 1000, -1000, 16384));
		directed_items.push_back(make_item(OP_PARK, -32768, -32768, 32768));
		directed_items.push_back(make_item(OP_PARK, 4096, 4096, 49152));
		directed_items.push_back(make_item(OP_PARK, 32767, -32768, 65535));
		directed_items.push_back(make_item(OP_PARK, 12345, -5432, 24576));
		directed_items.push_back(make_item(OP_INV_PARK, 32767, 32767, 0));
		directed_items.push_back(make_item(OP_INV_PARK, -32768, 0, 16384));
		directed_items.push_back(make_item(OP_INV_PARK, 0, -32768, 32767));
		directed_items.push_back(make_item(OP_INV_PARK, -32768, -32768, 49151));
		directed_items.push_back(make_item(OP_INV_PARK, 32767, -1, 65535));
		directed_items.push_back(make_item(OP_INV_PARK, -2000, 3000, 40000));
		foreach (directed_items[i]) begin
			issue(directed_items[i]);
			pace(i == directed_items.size() - 1);
		end

		for (int n = 0; n < 400; n++) begin
			issue(make_item(op_t'($urandom_range(0, 3)), pick_value(), pick_value(),
				pick_angle()));
			pace(n == 199 || n == 399);
		end

		repeat (10) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
src/cpt_pkg.sv
src/cpt_sine_lookup.sv
src/clarke_park_transform_unit.sv
src/cpt_checker.sv
tb/clarke_park_result_check.sv
tb/clarke_park_transform_unit_tb.sv
